// File: hw/rtl/arft_pkg.sv
// Package with shared types, codes and constants of the advertisement report filter.
`timescale 1ns / 1ps
package arft_pkg;

	localparam int TABLE_DEPTH    = 10;
	localparam int FILTER_ENTRIES = 4;
	localparam int MAX_PAYLOAD    = 31;

	localparam int ADDR_W   = 48;
	localparam int STR_W    = 8;
	localparam int PLEN_W   = 8;
	localparam int LEN_W    = 5;
	localparam int SLOT_W   = 4;
	localparam int COUNT_W  = 4;
	localparam int CFG_IDX_W = 3;
	localparam int IDX_W    = $clog2(TABLE_DEPTH);
	localparam int FCNT_W   = 3;

	localparam logic signed [STR_W-1:0] THRESHOLD_RESET = -8'sd75;

	typedef enum logic [2:0] {
		ACT_DROPPED   = 3'd0,
		ACT_APPENDED  = 3'd1,
		ACT_OVERWROTE = 3'd2,
		ACT_REFRESHED = 3'd3,
		ACT_CLEARED   = 3'd4
	} arft_action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RECEIVE_ENABLE     = 3'd0,
		CFG_FILTER_MODE        = 3'd1,
		CFG_FILTER_COUNT       = 3'd2,
		CFG_STRENGTH_THRESHOLD = 3'd3,
		CFG_FILTER_ENTRY_0     = 3'd4,
		CFG_FILTER_ENTRY_1     = 3'd5,
		CFG_FILTER_ENTRY_2     = 3'd6,
		CFG_FILTER_ENTRY_3     = 3'd7
	} arft_cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_OPEN    = 2'd0,
		MODE_ADDRESS = 2'd1,
		MODE_KIND    = 2'd2,
		MODE_DROP    = 2'd3
	} arft_mode_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic commit;
	} arft_cmd_t;

endpackage

// File: hw/rtl/adv_report_filter_table_top.sv
// Top level of the advertisement report filter with its sender table.
`timescale 1ns / 1ps
// Each input beat (a report or a table clear) yields exactly one result beat.
// An item is first captured into the input register; then, in the evaluation
// state, the filter, the ten-slot sender compare and the table write-back
// all complete and the result register is loaded. The block is ready for the
// next item right after, even while the previous result still waits on
// out_stall; only when that result has not been taken does evaluation wait.
// Configuration writes are registered and belong to idle periods.
module adv_report_filter_table_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [arft_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [arft_pkg::ADDR_W-1:0]        cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               func,
	input  logic [arft_pkg::ADDR_W-1:0]        sender_address,
	input  logic signed [arft_pkg::STR_W-1:0]  signal_strength,
	input  logic [arft_pkg::PLEN_W-1:0]        payload_length,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [2:0]                         action,
	output logic [arft_pkg::SLOT_W-1:0]        slot_index,
	output logic [arft_pkg::LEN_W-1:0]         stored_length,
	output logic [arft_pkg::COUNT_W-1:0]       entry_count
);
	import arft_pkg::*;

	arft_cmd_t cmd;

	arft_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	arft_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.func            (func),
		.sender_address  (sender_address),
		.signal_strength (signal_strength),
		.payload_length  (payload_length),
		.action          (action),
		.slot_index      (slot_index),
		.stored_length   (stored_length),
		.entry_count     (entry_count)
	);

endmodule

// File: hw/rtl/arft_ctrl.sv
// Controller state machine: input capture, evaluation and output beat handshake.
`timescale 1ns / 1ps
module arft_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	output arft_pkg::arft_cmd_t cmd
);
	import arft_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EVAL = 2'b10
	} arft_state_t;

	arft_state_t state_q;
	logic        out_valid_q;
	logic        out_free;

	assign out_free    = !out_valid_q || !out_stall;
	assign in_stall    = (state_q != ST_IDLE);
	assign cmd.capture = (state_q == ST_IDLE) && in_valid;
	assign cmd.commit  = (state_q == ST_EVAL) && out_free;
	assign out_valid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: hw/rtl/arft_datapath.sv
// Datapath: configuration registers, sender table, filter and result registers.
`timescale 1ns / 1ps
module arft_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  arft_pkg::arft_cmd_t                  cmd,
	input  logic                                 cfg_write,
	input  logic [arft_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [arft_pkg::ADDR_W-1:0]          cfg_data,
	input  logic                                 func,
	input  logic [arft_pkg::ADDR_W-1:0]          sender_address,
	input  logic signed [arft_pkg::STR_W-1:0]    signal_strength,
	input  logic [arft_pkg::PLEN_W-1:0]          payload_length,
	output logic [2:0]                           action,
	output logic [arft_pkg::SLOT_W-1:0]          slot_index,
	output logic [arft_pkg::LEN_W-1:0]           stored_length,
	output logic [arft_pkg::COUNT_W-1:0]         entry_count
);
	import arft_pkg::*;

	// Configuration.
	logic                     rx_en_q;
	logic [1:0]               mode_q;
	logic [FCNT_W-1:0]        fcount_q;
	logic signed [STR_W-1:0]  thresh_q;
	logic [ADDR_W-1:0]        fentry_q [FILTER_ENTRIES];

	// Captured input beat.
	logic                     func_q;
	logic [ADDR_W-1:0]        addr_q;
	logic signed [STR_W-1:0]  str_q;
	logic [PLEN_W-1:0]        plen_q;

	// Sender table.
	logic [ADDR_W-1:0]        sender_q [TABLE_DEPTH];
	logic [STR_W-1:0]         strength_q [TABLE_DEPTH];
	logic [LEN_W-1:0]         length_q [TABLE_DEPTH];
	logic [COUNT_W-1:0]       count_q;
	logic [SLOT_W-1:0]        ptr_q;

	// Result registers.
	logic [2:0]               action_q;
	logic [SLOT_W-1:0]        slot_q;
	logic [LEN_W-1:0]         stored_q;
	logic [COUNT_W-1:0]       entry_q;

	logic [FCNT_W-1:0]        fuse;
	logic                     pass;
	logic                     found;
	logic [IDX_W-1:0]         hit_idx;
	logic [LEN_W-1:0]         clamped;
	logic [SLOT_W-1:0]        ring_slot;
	logic [SLOT_W-1:0]        wr_slot;
	logic                     do_write;
	logic                     do_new;
	logic [2:0]               nxt_action;
	logic [SLOT_W-1:0]        nxt_slot;
	logic [LEN_W-1:0]         nxt_stored;
	logic [COUNT_W-1:0]       nxt_count;
	logic [SLOT_W-1:0]        nxt_ptr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_en_q  <= 1'b0;
			mode_q   <= MODE_OPEN;
			fcount_q <= '0;
			thresh_q <= THRESHOLD_RESET;
			for (int i = 0; i < FILTER_ENTRIES; i++) begin
				fentry_q[i] <= '0;
			end
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_RECEIVE_ENABLE:     rx_en_q  <= cfg_data[0];
				CFG_FILTER_MODE:        mode_q   <= cfg_data[1:0];
				CFG_FILTER_COUNT:       fcount_q <= cfg_data[FCNT_W-1:0];
				CFG_STRENGTH_THRESHOLD: thresh_q <= cfg_data[STR_W-1:0];
				CFG_FILTER_ENTRY_0:     fentry_q[0] <= cfg_data;
				CFG_FILTER_ENTRY_1:     fentry_q[1] <= cfg_data;
				CFG_FILTER_ENTRY_2:     fentry_q[2] <= cfg_data;
				CFG_FILTER_ENTRY_3:     fentry_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			addr_q <= sender_address;
			str_q  <= signal_strength;
			plen_q <= payload_length;
		end
	end

	// Filter decision; counts above the entry total act as the total.
	always_comb begin
		fuse = (fcount_q > FCNT_W'(FILTER_ENTRIES)) ? FCNT_W'(FILTER_ENTRIES) : fcount_q;
		pass = 1'b0;
		case (mode_q)
			MODE_OPEN: pass = (str_q > thresh_q);
			MODE_ADDRESS: begin
				for (int i = 0; i < FILTER_ENTRIES; i++) begin
					if ((FCNT_W'(i) < fuse) && (fentry_q[i] == addr_q)) begin
						pass = 1'b1;
					end
				end
			end
			MODE_KIND: begin
				for (int i = 0; i < FILTER_ENTRIES; i++) begin
					if ((FCNT_W'(i) < fuse) &&
					    (fentry_q[i][ADDR_W-1:ADDR_W-8] == addr_q[ADDR_W-1:ADDR_W-8])) begin
						pass = 1'b1;
					end
				end
			end
			default: pass = 1'b0;
		endcase
	end

	// Lowest valid slot holding the sender.
	always_comb begin
		found   = 1'b0;
		hit_idx = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if ((COUNT_W'(i) < count_q) && (sender_q[i] == addr_q)) begin
				found   = 1'b1;
				hit_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		clamped    = (plen_q > PLEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : plen_q[LEN_W-1:0];
		ring_slot  = (ptr_q >= SLOT_W'(TABLE_DEPTH)) ? '0 : ptr_q;
		nxt_action = ACT_DROPPED;
		nxt_slot   = '0;
		nxt_stored = '0;
		nxt_count  = count_q;
		nxt_ptr    = ptr_q;
		do_write   = 1'b0;
		do_new     = 1'b0;
		wr_slot    = '0;
		if (func_q) begin
			nxt_action = ACT_CLEARED;
			nxt_count  = '0;
			nxt_ptr    = '0;
		end else if (rx_en_q && pass) begin
			do_write   = 1'b1;
			nxt_stored = clamped;
			if (found) begin
				nxt_action = ACT_REFRESHED;
				wr_slot    = SLOT_W'(hit_idx);
			end else if (count_q < COUNT_W'(TABLE_DEPTH)) begin
				nxt_action = ACT_APPENDED;
				do_new     = 1'b1;
				wr_slot    = SLOT_W'(count_q);
				nxt_count  = count_q + COUNT_W'(1);
			end else begin
				nxt_action = ACT_OVERWROTE;
				do_new     = 1'b1;
				wr_slot    = ring_slot;
				nxt_ptr    = (ring_slot + SLOT_W'(1) >= SLOT_W'(TABLE_DEPTH)) ?
				             '0 : ring_slot + SLOT_W'(1);
			end
			nxt_slot = wr_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q   <= '0;
		end else if (cmd.commit) begin
			count_q <= nxt_count;
			ptr_q   <= nxt_ptr;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && do_write) begin
			length_q[wr_slot[IDX_W-1:0]] <= clamped;
			if (do_new) begin
				sender_q[wr_slot[IDX_W-1:0]]   <= addr_q;
				strength_q[wr_slot[IDX_W-1:0]] <= str_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			action_q <= nxt_action;
			slot_q   <= nxt_slot;
			stored_q <= nxt_stored;
			entry_q  <= nxt_count;
		end
	end

	assign action        = action_q;
	assign slot_index    = slot_q;
	assign stored_length = stored_q;
	assign entry_count   = entry_q;

endmodule
